>>> src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is low.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is low.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mslb_pkg.sv
`default_nettype none

package mslb_pkg;

    // Input item opcodes; code 3 is ignored
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_TICK  = 2'd2
    } t_opcode;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PIN_OFF = 2'd1;
    localparam logic [1:0] ST_NO_SLOT = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_STOP_EMIT,
        S_WALK
    } t_state;

    // Kind of result the datapath builds this cycle
    typedef enum logic [2:0] {
        RES_NONE,
        RES_START,
        RES_REFUSE,
        RES_STOP,
        RES_STOP_MISS,
        RES_IGNORE,
        RES_TICK_SLOT,
        RES_TICK_EMPTY
    } t_res_kind;

    // Commands from controller to datapath
    typedef struct packed {
        logic      take_item;
        logic      stop_rd;
        logic      walk_first;
        logic      walk_next;
        logic      tick_begin;
        t_res_kind res;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        t_opcode op;
        logic    start_ok;
        logic    stop_ok;
        logic    timer_on;
        logic    any_live;
        logic    has_next;
        logic    out_free;
    } t_dp_status;

endpackage

`default_nettype wire

>>> src/mslb_ram.sv
`default_nettype none

module mslb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry into the output register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/mslb_ctrl.sv
`default_nettype none

module mslb_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire mslb_pkg::t_dp_status i_status,
    output mslb_pkg::t_dp_cmd         o_cmd
);

    import mslb_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state           = r_state;
        o_cmd.take_item   = 1'b0;
        o_cmd.stop_rd     = 1'b0;
        o_cmd.walk_first  = 1'b0;
        o_cmd.walk_next   = 1'b0;
        o_cmd.tick_begin  = 1'b0;
        o_cmd.res         = RES_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.take_item = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_status.op)
                    OP_START: begin
                        if (i_status.out_free) begin
                            o_cmd.res = i_status.start_ok ? RES_START : RES_REFUSE;
                            n_state   = S_IDLE;
                        end
                    end
                    OP_STOP: begin
                        if (i_status.stop_ok) begin
                            o_cmd.stop_rd = 1'b1;
                            n_state       = S_STOP_EMIT;
                        end else if (i_status.out_free) begin
                            o_cmd.res = RES_STOP_MISS;
                            n_state   = S_IDLE;
                        end
                    end
                    OP_TICK: begin
                        if (!i_status.timer_on) begin
                            if (i_status.out_free) begin
                                o_cmd.res = RES_IGNORE;
                                n_state   = S_IDLE;
                            end
                        end else if (i_status.any_live) begin
                            o_cmd.tick_begin = 1'b1;
                            o_cmd.walk_first = 1'b1;
                            n_state          = S_WALK;
                        end else if (i_status.out_free) begin
                            o_cmd.res = RES_TICK_EMPTY;
                            n_state   = S_IDLE;
                        end
                    end
                    default: begin
                        if (i_status.out_free) begin
                            o_cmd.res = RES_IGNORE;
                            n_state   = S_IDLE;
                        end
                    end
                endcase
            end
            S_STOP_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.res = RES_STOP;
                    n_state   = S_IDLE;
                end
            end
            S_WALK: begin
                // One live slot per cycle while the output register is free; the next read overlaps this write
                if (i_status.out_free) begin
                    o_cmd.res = RES_TICK_SLOT;
                    if (i_status.has_next) begin
                        o_cmd.walk_next = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

>>> src/mslb_dp.sv
`default_nettype none

module mslb_dp #(
    parameter int SLOT_COUNT = 20,
    parameter int PIN_COUNT  = 32,
    parameter int TIME_BITS  = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire mslb_pkg::t_dp_cmd    i_cmd,
    output mslb_pkg::t_dp_status      o_status,
    input  wire logic [1:0]           i_opcode,
    input  wire logic [4:0]           i_pin,
    input  wire logic                 i_active_level,
    input  wire logic                 i_blink_mode,
    input  wire logic [15:0]          i_on_ticks,
    input  wire logic [15:0]          i_off_ticks,
    input  wire logic [15:0]          i_blink_limit,
    input  wire logic [4:0]           i_slot,
    input  wire logic                 i_cfg_valid,
    input  wire logic [31:0]          i_cfg_data,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output logic [1:0]                o_status_code,
    output logic [4:0]                o_slot_index,
    output logic                      o_write_valid,
    output logic [4:0]                o_pin_out,
    output logic                      o_level_out,
    output logic                      o_ticking,
    output logic                      o_last
);

    import mslb_pkg::*;

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int TB = TIME_BITS;
    localparam logic [TB:0]   ONE_P = 1;
    localparam logic [TB-1:0] ONE_T = 1;

    // One slot record as held in the slot memory
    typedef struct packed {
        logic [4:0]    pin;
        logic          pol;
        logic          blink;
        logic [TB-1:0] on_ticks;
        logic [TB-1:0] off_ticks;
        logic [TB-1:0] limit;
        logic [TB:0]   phase;
        logic [TB-1:0] done;
    } t_rec;

    // Outcome of one tick on a slot
    typedef struct packed {
        logic [TB:0]   phase;
        logic [TB-1:0] done;
        logic          ended;
        logic          lvl;
    } t_adv;

    // Advance one slot by one tick; the period sum and both count compares run side by side
    function automatic t_adv f_advance(t_rec rec);
        logic [TB:0] period;
        logic [TB:0] ph1;
        logic        wrap;
        logic        ge_now;
        logic        ge_inc;
        logic        ph_ge_on;
        logic        dark;
        t_adv        a;
        period   = {1'b0, rec.on_ticks} + {1'b0, rec.off_ticks};
        ph1      = rec.phase + ONE_P;
        wrap     = (ph1 == period);
        ge_now   = (rec.done >= rec.limit);
        ge_inc   = ((rec.done + ONE_T) >= rec.limit);
        ph_ge_on = (ph1 >= {1'b0, rec.on_ticks});
        dark     = wrap ? (rec.on_ticks == '0) : ph_ge_on;
        a.phase  = !rec.blink ? rec.phase : (wrap ? '0 : ph1);
        a.done   = (rec.blink && wrap) ? rec.done + ONE_T : rec.done;
        a.ended  = rec.blink && (wrap ? ge_inc : ge_now);
        a.lvl    = (a.ended || (rec.blink && dark)) ? ~rec.pol : rec.pol;
        return a;
    endfunction

    // Item register
    logic [1:0]          r_op;
    logic [4:0]          r_pin;
    logic                r_lvl;
    logic                r_blink;
    logic [TB-1:0]       r_on;
    logic [TB-1:0]       r_off;
    logic [TB-1:0]       r_lim;
    logic [4:0]          r_slot;

    // Control state
    logic [31:0]           r_mask;
    logic [SLOT_COUNT-1:0] r_live;
    logic [SLOT_COUNT-1:0] r_ends;
    logic                  r_timer;
    logic                  r_still;
    logic [SW-1:0]         r_walk;

    // End-prediction stage
    logic                  r_pd_vld;
    logic [SW-1:0]         r_pd_idx;
    t_rec                  r_pd_rec;

    // Output register
    logic       r_out_vld;
    logic [1:0] r_out_status;
    logic [4:0] r_out_idx;
    logic       r_out_wv;
    logic [4:0] r_out_pin;
    logic       r_out_lvl;
    logic       r_out_tick;
    logic       r_out_last;
    logic [1:0] n_out_status;
    logic [4:0] n_out_idx;
    logic       n_out_wv;
    logic [4:0] n_out_pin;
    logic       n_out_lvl;
    logic       n_out_tick;
    logic       n_out_last;

    logic [SW-1:0] w_free;
    logic          w_has_free;
    logic [SW-1:0] w_first;
    logic [SW-1:0] w_next;
    logic          w_has_next;
    logic [SW-1:0] w_stop_idx;
    logic          w_pin_ok;
    logic          w_stop_ok;
    logic          w_still;
    logic          w_out_free;
    logic          w_emit;

    t_rec          w_rd;
    t_rec          w_new_rec;
    t_rec          w_upd_rec;
    t_adv          w_adv;
    t_adv          w_pd_adv;

    logic                  w_we;
    logic [SW-1:0]         w_waddr;
    t_rec                  w_wdata;
    logic                  w_re;
    logic [SW-1:0]         w_raddr;
    logic [$bits(t_rec)-1:0] w_rdata;

    // Capture the item on transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_op    <= i_opcode;
            r_pin   <= i_pin;
            r_lvl   <= i_active_level;
            r_blink <= i_blink_mode;
            r_on    <= TB'(i_on_ticks);
            r_off   <= TB'(i_off_ticks);
            r_lim   <= TB'(i_blink_limit);
            r_slot  <= i_slot;
        end
    end

    // Lowest free slot, first live slot and next live slot above the walk
    always_comb begin
        w_free     = '0;
        w_has_free = 1'b0;
        w_first    = '0;
        w_next     = '0;
        w_has_next = 1'b0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!r_live[i]) begin
                w_free     = SW'(i);
                w_has_free = 1'b1;
            end
            if (r_live[i]) begin
                w_first = SW'(i);
            end
            if (r_live[i] && (i > int'(r_walk))) begin
                w_next     = SW'(i);
                w_has_next = 1'b1;
            end
        end
    end

    assign w_stop_idx = SW'(r_slot);
    assign w_pin_ok   = ({27'd0, r_pin} < 32'(PIN_COUNT)) && r_mask[r_pin];
    assign w_stop_ok  = ({27'd0, r_slot} < 32'(SLOT_COUNT)) && r_live[w_stop_idx];
    assign w_still    = |(r_live & ~r_ends);
    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_emit     = (i_cmd.res != RES_NONE);

    assign o_status.op       = t_opcode'(r_op);
    assign o_status.start_ok = w_pin_ok && w_has_free;
    assign o_status.stop_ok  = w_stop_ok;
    assign o_status.timer_on = r_timer;
    assign o_status.any_live = |r_live;
    assign o_status.has_next = w_has_next;
    assign o_status.out_free = w_out_free;

    // Slot memory: write the current record, read the next one
    assign w_rd = t_rec'(w_rdata);

    always_comb begin
        w_new_rec           = '0;
        w_new_rec.pin       = r_pin;
        w_new_rec.pol       = r_lvl;
        w_new_rec.blink     = r_blink;
        w_new_rec.on_ticks  = r_on;
        w_new_rec.off_ticks = r_off;
        w_new_rec.limit     = r_lim;
    end

    assign w_adv = f_advance(w_rd);

    always_comb begin
        w_upd_rec       = w_rd;
        w_upd_rec.phase = w_adv.phase;
        w_upd_rec.done  = w_adv.done;
    end

    assign w_we    = (i_cmd.res == RES_START) || (i_cmd.res == RES_TICK_SLOT);
    assign w_waddr = (i_cmd.res == RES_START) ? w_free : r_walk;
    assign w_wdata = (i_cmd.res == RES_START) ? w_new_rec : w_upd_rec;
    assign w_re    = i_cmd.stop_rd || i_cmd.walk_first || i_cmd.walk_next;

    always_comb begin
        if (i_cmd.stop_rd) begin
            w_raddr = w_stop_idx;
        end else if (i_cmd.walk_first) begin
            w_raddr = w_first;
        end else begin
            w_raddr = w_next;
        end
    end

    mslb_ram #(
        .WIDTH ($bits(t_rec)),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Predict whether a slot ends on its next tick, in the cycle after its record is written
    assign w_pd_adv = f_advance(r_pd_rec);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_pd_idx <= w_waddr;
            r_pd_rec <= w_wdata;
        end
    end

    // Live bits, end flags, timer, walk pointer and mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= '0;
            r_live   <= '0;
            r_ends   <= '0;
            r_timer  <= 1'b0;
            r_still  <= 1'b0;
            r_walk   <= '0;
            r_pd_vld <= 1'b0;
        end else begin
            r_pd_vld <= w_we;
            if (i_cfg_valid) begin
                r_mask <= i_cfg_data;
            end
            if (r_pd_vld) begin
                r_ends[r_pd_idx] <= w_pd_adv.ended;
            end
            if (i_cmd.tick_begin) begin
                r_still <= w_still;
            end
            if (i_cmd.walk_first) begin
                r_walk <= w_first;
            end else if (i_cmd.walk_next) begin
                r_walk <= w_next;
            end
            case (i_cmd.res)
                RES_START: begin
                    r_live[w_free] <= 1'b1;
                    r_timer        <= 1'b1;
                end
                RES_STOP: begin
                    r_live[w_stop_idx] <= 1'b0;
                end
                RES_TICK_SLOT: begin
                    if (w_adv.ended) begin
                        r_live[r_walk] <= 1'b0;
                    end
                    if (!w_has_next) begin
                        r_timer <= r_still;
                    end
                end
                RES_TICK_EMPTY: begin
                    r_timer <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Build the next result
    always_comb begin
        n_out_status = ST_OK;
        n_out_idx    = '0;
        n_out_wv     = 1'b0;
        n_out_pin    = '0;
        n_out_lvl    = 1'b0;
        n_out_tick   = r_timer;
        n_out_last   = 1'b1;
        case (i_cmd.res)
            RES_START: begin
                n_out_idx  = 5'(w_free);
                n_out_wv   = 1'b1;
                n_out_pin  = r_pin;
                n_out_lvl  = r_lvl;
                n_out_tick = 1'b1;
            end
            RES_REFUSE: begin
                n_out_status = w_pin_ok ? ST_NO_SLOT : ST_PIN_OFF;
            end
            RES_STOP: begin
                n_out_idx = r_slot;
                n_out_wv  = 1'b1;
                n_out_pin = w_rd.pin;
                n_out_lvl = ~w_rd.pol;
            end
            RES_STOP_MISS: begin
                n_out_idx = r_slot;
            end
            RES_TICK_SLOT: begin
                n_out_idx  = 5'(r_walk);
                n_out_wv   = 1'b1;
                n_out_pin  = w_rd.pin;
                n_out_lvl  = w_adv.lvl;
                n_out_tick = r_still;
                n_out_last = !w_has_next;
            end
            RES_TICK_EMPTY: begin
                n_out_tick = w_still;
            end
            default: begin
            end
        endcase
    end

    // Output register: hold until transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_status <= n_out_status;
            r_out_idx    <= n_out_idx;
            r_out_wv     <= n_out_wv;
            r_out_pin    <= n_out_pin;
            r_out_lvl    <= n_out_lvl;
            r_out_tick   <= n_out_tick;
            r_out_last   <= n_out_last;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_status_code = r_out_status;
    assign o_slot_index  = r_out_idx;
    assign o_write_valid = r_out_wv;
    assign o_pin_out     = r_out_pin;
    assign o_level_out   = r_out_lvl;
    assign o_ticking     = r_out_tick;
    assign o_last        = r_out_last;

endmodule

`default_nettype wire

>>> src/multi_slot_led_blink_scheduler_top.sv
// LED slot scheduler. Start, stop and tick items arrive on a valid/ready channel; results
// leave on another through a one-entry output register, so an item may be taken while the
// last result still waits. An item is taken only when the previous one has finished. A start,
// refused start, ignored item or ignored stop gives its result from the decode state, a valid
// stop from the stop-emit state after its slot record is read. While the timer runs, a tick
// gives one pin write per live slot, one per cycle while the output is not stalled; the pace is
// set by the slot memory, which writes one record and reads the next each cycle. A stalled
// output port holds the walk. The pin enable mask is written on its own port and is always ready.
`default_nettype none

`include "assert_macros.svh"

module multi_slot_led_blink_scheduler_top #(
    parameter int SLOT_COUNT = 20,
    parameter int PIN_COUNT  = 32,
    parameter int TIME_BITS  = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [4:0]  i_pin,
    input  wire logic        i_active_level,
    input  wire logic        i_blink_mode,
    input  wire logic [15:0] i_on_ticks,
    input  wire logic [15:0] i_off_ticks,
    input  wire logic [15:0] i_blink_limit,
    input  wire logic [4:0]  i_slot,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [4:0]       o_slot_index,
    output logic             o_write_valid,
    output logic [4:0]       o_pin_out,
    output logic             o_level_out,
    output logic             o_ticking,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data
);

    import mslb_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    mslb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    mslb_dp #(
        .SLOT_COUNT (SLOT_COUNT),
        .PIN_COUNT  (PIN_COUNT),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_opcode       (i_opcode),
        .i_pin          (i_pin),
        .i_active_level (i_active_level),
        .i_blink_mode   (i_blink_mode),
        .i_on_ticks     (i_on_ticks),
        .i_off_ticks    (i_off_ticks),
        .i_blink_limit  (i_blink_limit),
        .i_slot         (i_slot),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_ready),
        .o_out_valid    (o_valid),
        .o_status_code  (o_status),
        .o_slot_index   (o_slot_index),
        .o_write_valid  (o_write_valid),
        .o_pin_out      (o_pin_out),
        .o_level_out    (o_level_out),
        .o_ticking      (o_ticking),
        .o_last         (o_last)
    );

    assign o_cfg_ready = 1'b1;

    // A result that writes no pin carries a zero pin and level
    `ASSERT_IMP(a_nowrite_zero, i_clk, i_rst_n, o_valid && !o_write_valid,
                (o_pin_out == 5'd0) && (o_level_out == 1'b0),
                "pin write fields set without write")
    // A refused start is a single result with no pin write
    `ASSERT_IMP(a_refuse_single, i_clk, i_rst_n, o_valid && (o_status != ST_OK),
                !o_write_valid && o_last,
                "refused start wrote a pin or was not last")
    // Only a tick walk gives several results, and each of them writes a pin
    `ASSERT_IMP(a_walk_writes, i_clk, i_rst_n, o_valid && !o_last,
                o_write_valid && (o_status == ST_OK),
                "non-final result without a pin write")
    // After a transfer in, the item is decoded before another is taken
    `ASSERT_NXT(a_decode_busy, i_clk, i_rst_n, w_cmd.take_item, !o_ready,
                "item taken while decoding")

endmodule

`default_nettype wire
